### sv/kcld_pkg.sv
// ----------------------------------------------------------------------------
// kcld_pkg
// shared types, constants and helpers of the key click / long-press detector
// ----------------------------------------------------------------------------
package kcld_pkg;

   localparam int unsigned NUM_KEYS   = 18;
   localparam int unsigned MASK_W     = 18;
   localparam int unsigned LANE_CNT   = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned KEY_W      = 16;
   localparam int unsigned BTN_W      = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned LANE_SHIFT  = 4;
   localparam int unsigned LANE_CTRL   = 5;
   localparam int unsigned LANE_MLEFT  = 16;
   localparam int unsigned LANE_MRIGHT = 17;

   localparam logic [TIME_W-1:0] CLICK_DELAY_RST     = TIME_W'(50);
   localparam logic [TIME_W-1:0] LONG_PRESS_TIME_RST = TIME_W'(500);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLICK_DELAY     = 2'd0,
      CSR_LONG_PRESS_TIME = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      COMBO_NONE  = 2'd0,
      COMBO_CTRL  = 2'd1,
      COMBO_SHIFT = 2'd2
   } combo_type;

   typedef struct packed {
      logic [TIME_W-1:0] click_delay;
      logic [TIME_W-1:0] long_press_time;
   } cfg_type;

   typedef struct packed {
      logic down;
      logic up;
      logic click;
      logic held;
      logic lng;
   } lane_evt_type;

   typedef struct packed {
      logic [MASK_W-1:0] down_mask;
      logic [MASK_W-1:0] up_mask;
      logic [MASK_W-1:0] click_mask;
      logic [MASK_W-1:0] held_mask;
      logic [MASK_W-1:0] long_mask;
      combo_type         combine_key;
   } rsp_word_type;

   // level of one lane from the raw tick word
   function automatic logic lane_level(input int unsigned lane,
                                       input logic [KEY_W-1:0] kb,
                                       input logic [BTN_W-1:0] ml,
                                       input logic [BTN_W-1:0] mr);
      logic lvl;
      lvl = 1'b0;
      if (lane < KEY_W) begin
         lvl = kb[lane[3:0]];
      end else if (lane == LANE_MLEFT) begin
         lvl = |ml;
      end else if (lane == LANE_MRIGHT) begin
         lvl = |mr;
      end
      return lvl;
   endfunction

endpackage

### sv/kcld_if.sv
// ----------------------------------------------------------------------------
// kcld_req_if / kcld_rsp_if
// valid/ready channels carrying tick words in and event words out
// ----------------------------------------------------------------------------
interface kcld_req_if;
   logic                               valid;
   logic                               ready;
   logic [kcld_pkg::TIME_W-1:0]        now_ms;
   logic [kcld_pkg::KEY_W-1:0]         key_bits;
   logic [kcld_pkg::BTN_W-1:0]         mouse_left;
   logic [kcld_pkg::BTN_W-1:0]         mouse_right;

   modport source (output valid, now_ms, key_bits, mouse_left, mouse_right, input ready);
   modport sink   (input valid, now_ms, key_bits, mouse_left, mouse_right, output ready);
endinterface

interface kcld_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [kcld_pkg::MASK_W-1:0]        down_mask;
   logic [kcld_pkg::MASK_W-1:0]        up_mask;
   logic [kcld_pkg::MASK_W-1:0]        click_mask;
   logic [kcld_pkg::MASK_W-1:0]        held_mask;
   logic [kcld_pkg::MASK_W-1:0]        long_mask;
   logic [1:0]                         combine_key;

   modport source (output valid, down_mask, up_mask, click_mask, held_mask, long_mask,
                   combine_key, input ready);
   modport sink   (input valid, down_mask, up_mask, click_mask, held_mask, long_mask,
                   combine_key, output ready);
endinterface

### sv/key_click_longpress_detector_unit.sv
// ----------------------------------------------------------------------------
// key_click_longpress_detector_unit
// per-key down/up/held/click/long-press detection over 18 lanes
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   req_ch   in   valid/ready      now_ms, key_bits, mouse_left, mouse_right
//   rsp_ch   out  valid/ready      down/up/click/held/long masks, combine_key
//   csr_*    in   csr_we           csr_index, csr_wdata (no read-back)
//
// one word per cycle while the skid entry is free; results are registered on accept
// all key lanes compute in parallel: two 16-bit subtracts and compares per lane
// output register plus one skid entry; req_ch.ready drops only when both hold words
// synchronous active-high reset clears lane levels, press times, tick time,
// and loads click_delay 50 / long_press_time 500
// ----------------------------------------------------------------------------
module key_click_longpress_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   kcld_req_if.sink                        req_ch,
   kcld_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [kcld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kcld_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kcld_pkg::cfg_type           cfg_ff;
   kcld_pkg::cfg_type           cfg_in;
   logic [kcld_pkg::TIME_W-1:0] prev_tick_ff;
   logic [kcld_pkg::TIME_W-1:0] prev_tick_in;
   logic                        accept;
   logic                        can_push;
   kcld_pkg::lane_evt_type      evt [kcld_pkg::MASK_W];

   // a tick word is taken whenever the skid entry is free
   assign req_ch.ready = can_push;
   assign accept       = req_ch.valid && can_push;

   // configuration registers, writes to unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (kcld_pkg::csr_idx_type'(csr_index))
            kcld_pkg::CSR_CLICK_DELAY:     cfg_in.click_delay     = csr_wdata;
            kcld_pkg::CSR_LONG_PRESS_TIME: cfg_in.long_press_time = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
      prev_tick_in = accept ? req_ch.now_ms : prev_tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_delay     <= kcld_pkg::CLICK_DELAY_RST;
         cfg_ff.long_press_time <= kcld_pkg::LONG_PRESS_TIME_RST;
         prev_tick_ff           <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         prev_tick_ff <= prev_tick_in;
      end
   end

   // key lanes; shift and ctrl lanes carry no events, lanes past the mask are absent
   for (genvar g = 0; g < kcld_pkg::MASK_W; g++) begin : g_lane
      if (g < kcld_pkg::LANE_CNT && g != kcld_pkg::LANE_SHIFT
          && g != kcld_pkg::LANE_CTRL) begin : g_on
         kcld_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .accept    (accept),
            .cur_level (kcld_pkg::lane_level(g, req_ch.key_bits,
                                             req_ch.mouse_left, req_ch.mouse_right)),
            .now_ms    (req_ch.now_ms),
            .prev_tick (prev_tick_ff),
            .cfg       (cfg_ff),
            .evt       (evt[g])
         );
      end else begin : g_off
         assign evt[g] = '0;
      end
   end

   // mask assembly, modifier code and output buffering
   kcld_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .evt         (evt),
      .ctrl_level  (req_ch.key_bits[kcld_pkg::LANE_CTRL]),
      .shift_level (req_ch.key_bits[kcld_pkg::LANE_SHIFT]),
      .can_push    (can_push),
      .rsp         (rsp_ch)
   );

endmodule

### sv/kcld_lane.sv
// ----------------------------------------------------------------------------
// kcld_lane
// one key lane: previous level, press timestamp and event decode
// ----------------------------------------------------------------------------
module kcld_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        cur_level,
   input  logic [kcld_pkg::TIME_W-1:0] now_ms,
   input  logic [kcld_pkg::TIME_W-1:0] prev_tick,
   input  kcld_pkg::cfg_type           cfg,
   output kcld_pkg::lane_evt_type      evt
);

   logic                        level_ff;
   logic                        level_in;
   logic [kcld_pkg::TIME_W-1:0] start_ff;
   logic [kcld_pkg::TIME_W-1:0] start_in;
   logic [kcld_pkg::TIME_W-1:0] hold_prev;
   logic [kcld_pkg::TIME_W-1:0] hold_now;

   // differences wrap mod 2^16
   assign hold_prev = prev_tick - start_ff;
   assign hold_now  = now_ms - start_ff;

   always_comb begin
      evt       = '0;
      evt.down  = !level_ff && cur_level;
      evt.up    = level_ff && !cur_level;
      evt.held  = level_ff && cur_level;
      evt.click = evt.up && (hold_now > cfg.click_delay) && (hold_now < cfg.long_press_time);
      evt.lng   = evt.held && (hold_prev <= cfg.long_press_time)
                  && (hold_now > cfg.long_press_time);
      level_in  = accept ? cur_level : level_ff;
      start_in  = (accept && evt.down) ? now_ms : start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         start_ff <= '0;
      end else begin
         level_ff <= level_in;
         start_ff <= start_in;
      end
   end

endmodule

### sv/kcld_merge.sv
// ----------------------------------------------------------------------------
// kcld_merge
// packs lane events into masks, output register plus skid stage
// ----------------------------------------------------------------------------
module kcld_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kcld_pkg::lane_evt_type evt [kcld_pkg::MASK_W],
   input  logic                   ctrl_level,
   input  logic                   shift_level,
   output logic                   can_push,
   kcld_rsp_if.source             rsp
);

   kcld_pkg::rsp_word_type word;
   kcld_pkg::rsp_word_type out_ff;
   kcld_pkg::rsp_word_type out_in;
   kcld_pkg::rsp_word_type skid_ff;
   kcld_pkg::rsp_word_type skid_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   logic                   pop;
   logic                   out_free;

   always_comb begin
      word = '0;
      for (int i = 0; i < kcld_pkg::MASK_W; i++) begin
         word.down_mask[i]  = evt[i].down;
         word.up_mask[i]    = evt[i].up;
         word.click_mask[i] = evt[i].click;
         word.held_mask[i]  = evt[i].held;
         word.long_mask[i]  = evt[i].lng;
      end
      if (ctrl_level) begin
         word.combine_key = kcld_pkg::COMBO_CTRL;
      end else if (shift_level) begin
         word.combine_key = kcld_pkg::COMBO_SHIFT;
      end else begin
         word.combine_key = kcld_pkg::COMBO_NONE;
      end
   end

   assign pop      = out_valid_ff && rsp.ready;
   assign out_free = !out_valid_ff || pop;
   assign can_push = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in       = word;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.down_mask   = out_ff.down_mask;
   assign rsp.up_mask     = out_ff.up_mask;
   assign rsp.click_mask  = out_ff.click_mask;
   assign rsp.held_mask   = out_ff.held_mask;
   assign rsp.long_mask   = out_ff.long_mask;
   assign rsp.combine_key = out_ff.combine_key;

endmodule
